>>> design/bce_pkg.sv
package bce_pkg;

    // Configuration port
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_INDEX_W = 1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_GENERATOR_POLYNOMIAL = 1'b0,
        CFG_START_REMAINDER      = 1'b1
    } cfg_reg_t;

    // Register reset values
    localparam logic [CFG_DATA_W-1:0] GEN_POLY_RST  = 32'h04C1_1DB7;
    localparam logic [CFG_DATA_W-1:0] START_REM_RST = 32'hFFFF_FFFF;

    // Message byte geometry
    localparam int BYTE_W = 8;

    // One byte request as held in the input register
    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              first_byte;
        logic              last_byte;
    } byte_req_t;

endpackage

>>> design/bce_cfg_regs.sv
module bce_cfg_regs
    import bce_pkg::*;
#(
    parameter int CRC_BITS = 32
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_wr_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wr_data,
    output logic [CRC_BITS-1:0]    gen_poly,
    output logic [CRC_BITS-1:0]    start_rem
);

    logic [CFG_DATA_W-1:0] gen_poly_reg;
    logic [CFG_DATA_W-1:0] start_rem_reg;

    // Register writes, no read-back
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gen_poly_reg  <= GEN_POLY_RST;
            start_rem_reg <= START_REM_RST;
        end else if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_wr_index))
                CFG_GENERATOR_POLYNOMIAL: gen_poly_reg  <= cfg_wr_data;
                CFG_START_REMAINDER:      start_rem_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // Fit to CRC width: truncate when narrower, zero-extend when wider
    assign gen_poly  = CRC_BITS'(gen_poly_reg);
    assign start_rem = CRC_BITS'(start_rem_reg);

endmodule

>>> design/bce_byte_div.sv
module bce_byte_div
    import bce_pkg::*;
#(
    parameter int CRC_BITS = 32
) (
    input  logic [CRC_BITS-1:0] rem_in,
    input  logic [BYTE_W-1:0]   data_byte,
    input  logic [CRC_BITS-1:0] gen_poly,
    output logic [CRC_BITS-1:0] rem_out
);

    logic [CRC_BITS-1:0] rem_work;

    // Byte into the top bits, then eight shift-and-reduce steps, MSB first
    always_comb begin
        rem_work = rem_in ^ (CRC_BITS'(data_byte) << (CRC_BITS - BYTE_W));
        for (int k = 0; k < BYTE_W; k++) begin
            if (rem_work[CRC_BITS-1]) begin
                rem_work = (rem_work << 1) ^ gen_poly;
            end else begin
                rem_work = rem_work << 1;
            end
        end
        rem_out = rem_work;
    end

endmodule

>>> design/bytewise_crc_engine.sv
// Bytewise CRC engine: MSB-first, non-reflected CRC over a byte stream, no
// final XOR. Each accepted byte request returns one result carrying the
// running remainder after that byte; tlast marks the message's finished CRC.
// A byte with the first-byte flag (s_tuser) reloads the start remainder.
// Throughput is one byte per clock while m_tready does not stall the result
// register: a byte is held in the input register, the eight-step division is
// unrolled between that register and the result register, and the running
// remainder is updated as the result is loaded. Write the polynomial and
// start remainder only while no request is in flight.
module bytewise_crc_engine
    import bce_pkg::*;
#(
    parameter int CRC_BITS = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Configuration write port
    input  logic                                cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0]              cfg_wr_index,
    input  logic [CFG_DATA_W-1:0]               cfg_wr_data,
    // Byte requests
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [BYTE_W-1:0]                   s_tdata,   // [7:0] data_byte
    input  logic                                s_tuser,   // [0] first_byte
    input  logic                                s_tlast,   // last_byte
    // CRC results
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [((CRC_BITS+7)/8)*8-1:0]       m_tdata,   // [CRC_BITS-1:0] crc_value
    output logic                                m_tlast    // is_final
);

    localparam int TDATA_W = ((CRC_BITS + 7) / 8) * 8;

    logic [CRC_BITS-1:0] gen_poly;
    logic [CRC_BITS-1:0] start_rem;

    logic                in_valid_reg;
    byte_req_t           in_req_reg;
    logic                advance;

    logic [CRC_BITS-1:0] running_rem_reg;
    logic [CRC_BITS-1:0] base_rem;
    logic [CRC_BITS-1:0] rem_next;

    logic                out_valid_reg;
    logic [CRC_BITS-1:0] out_crc_reg;
    logic                out_last_reg;

    bce_cfg_regs #(
        .CRC_BITS (CRC_BITS)
    ) u_cfg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .gen_poly     (gen_poly),
        .start_rem    (start_rem)
    );

    // Handshake: input register moves on when the result register is empty or being read
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tvalid && s_tready) begin
            in_req_reg.data_byte  <= s_tdata;
            in_req_reg.first_byte <= s_tuser;
            in_req_reg.last_byte  <= s_tlast;
        end
    end

    // Remainder source: start value on a message's first byte
    assign base_rem = in_req_reg.first_byte ? start_rem : running_rem_reg;

    bce_byte_div #(
        .CRC_BITS (CRC_BITS)
    ) u_div (
        .rem_in    (base_rem),
        .data_byte (in_req_reg.data_byte),
        .gen_poly  (gen_poly),
        .rem_out   (rem_next)
    );

    // Running remainder and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_rem_reg <= CRC_BITS'(START_REM_RST);
            out_valid_reg   <= 1'b0;
        end else begin
            if (advance) begin
                running_rem_reg <= rem_next;
                out_valid_reg   <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg   <= 1'b0;
            end
        end
        if (advance) begin
            out_crc_reg  <= rem_next;
            out_last_reg <= in_req_reg.last_byte;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = TDATA_W'(out_crc_reg);
    assign m_tlast  = out_last_reg;

endmodule

>>> design/bce_checker.sv
module bce_checker
    import bce_pkg::*;
#(
    parameter int CRC_BITS = 32
) (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [((CRC_BITS+7)/8)*8-1:0] m_tdata,
    input logic                          m_tlast
);

    // Reset empties the result register
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // A stalled result keeps its payload
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    // With the result register empty a byte is always taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input blocked while output empty");

    // An accepted byte leads to a pending result once it has passed the input register
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |-> ##2 m_tvalid)
        else $error("accepted byte produced no result");

endmodule

bind bytewise_crc_engine bce_checker #(
    .CRC_BITS (CRC_BITS)
) u_bce_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

>>> dv/tb_top.sv
module tb_top;
    import bce_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CRC_W       = 32;
    localparam int MSG_PHASES  = 10;
    localparam int PHASE_ITEMS = 130;
    localparam int DRAIN_CYCS  = 8;
    localparam int CYCLE_LIMIT = 400000;

    // Expected result of one byte request
    typedef struct packed {
        logic [CRC_W-1:0] crc_value;
        logic             is_final;
    } crc_result_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_wr_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wr_data = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [BYTE_W-1:0]      s_tdata = '0;    // [7:0] data_byte
    logic                   s_tuser = 1'b0;  // [0] first_byte
    logic                   s_tlast = 1'b0;  // last_byte
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [CRC_W-1:0]       m_tdata;         // [31:0] crc_value
    logic                   m_tlast;         // is_final

    bytewise_crc_engine #(.CRC_BITS(CRC_W)) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .s_tlast      (s_tlast),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // Shadow of the engine's registers and running remainder
    logic [CRC_W-1:0] poly_shadow  = GEN_POLY_RST;
    logic [CRC_W-1:0] start_shadow = START_REM_RST;
    logic [CRC_W-1:0] rem_shadow   = START_REM_RST;

    byte_req_t   byte_req_q[$];
    crc_result_t crc_expect_q[$];
    int          mismatches = 0;
    int          cycles = 0;

    // One byte of MSB-first polynomial division
    function automatic logic [CRC_W-1:0] divide_byte(logic [CRC_W-1:0] rem,
                                                      logic [7:0] data,
                                                      logic [CRC_W-1:0] poly);
        logic [CRC_W-1:0] r;
        logic             top;
        r = rem ^ {data, {(CRC_W-8){1'b0}}};
        for (int k = 0; k < 8; k++) begin
            top = r[CRC_W-1];
            r   = r << 1;
            if (top) r = r ^ poly;
        end
        return r;
    endfunction

    // Advance the shadow remainder with one accepted request
    function automatic crc_result_t crc_after(byte_req_t req);
        crc_result_t res;
        logic [CRC_W-1:0] base;
        base = req.first_byte ? start_shadow : rem_shadow;
        rem_shadow = divide_byte(base, req.data_byte, poly_shadow);
        res.crc_value = rem_shadow;
        res.is_final  = req.last_byte;
        return res;
    endfunction

    // Idle length per item; burst mode gives runs without gaps
    function automatic int draw_wait(bit burst);
        return burst ? 0 : $urandom_range(0, 13);
    endfunction

    task automatic report_mismatch(string what, crc_result_t want, crc_result_t got);
        if (mismatches < 10)
            $display("mismatch (%s): expected crc=%h final=%b, got crc=%h final=%b",
                     what, want.crc_value, want.is_final, got.crc_value, got.is_final);
        mismatches++;
    endtask

    // Request driver
    int src_gap = 0;
    bit src_burst = 1'b0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            src_gap = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                crc_expect_q.push_back(crc_after({s_tdata, s_tuser, s_tlast}));
                if ($urandom_range(0, 49) == 0) src_burst = ~src_burst;
                src_gap = draw_wait(src_burst);
                if (src_gap == 0 && byte_req_q.size() > 0) begin
                    {s_tdata, s_tuser, s_tlast} <= byte_req_q.pop_front();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end else if (!s_tvalid) begin
                if (src_gap > 0) src_gap--;
                if (src_gap == 0 && byte_req_q.size() > 0) begin
                    {s_tdata, s_tuser, s_tlast} <= byte_req_q.pop_front();
                    s_tvalid <= 1'b1;
                end
            end
        end
    end

    // Result monitor with random backpressure
    int snk_stall = 0;
    bit snk_burst = 1'b0;
    crc_result_t got_res;
    crc_result_t want_res;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            snk_stall = $urandom_range(0, 13);
        end else begin
            if (m_tvalid && m_tready) begin
                got_res.crc_value = m_tdata;
                got_res.is_final  = m_tlast;
                if (crc_expect_q.size() == 0) begin
                    want_res = '0;
                    report_mismatch("unexpected result", want_res, got_res);
                end else begin
                    want_res = crc_expect_q.pop_front();
                    if (got_res !== want_res) report_mismatch("field", want_res, got_res);
                end
                if ($urandom_range(0, 49) == 0) snk_burst = ~snk_burst;
                snk_stall = draw_wait(snk_burst);
                if (snk_stall > 0) m_tready <= 1'b0;
            end else if (!m_tready) begin
                if (snk_stall > 0) snk_stall--;
                if (snk_stall == 0) m_tready <= 1'b1;
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAIL bytewise_crc_engine");
            $finish;
        end
    end

    task automatic add_byte(logic [7:0] data, bit first, bit last);
        byte_req_t req;
        req.data_byte  = data;
        req.first_byte = first;
        req.last_byte  = last;
        byte_req_q.push_back(req);
    endtask

    // Sampled mid-cycle so the driver's updates at the edge have settled
    task automatic wait_idle();
        @(negedge aclk);
        while (byte_req_q.size() > 0 || s_tvalid || crc_expect_q.size() > 0)
            @(negedge aclk);
        repeat (DRAIN_CYCS) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
        @(posedge aclk);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= value;
        @(posedge aclk);
        cfg_wr_en    <= 1'b0;
        if (idx == CFG_GENERATOR_POLYNOMIAL) poly_shadow = value;
        else start_shadow = value;
    endtask

    function automatic logic [31:0] pick_reg_value();
        case ($urandom_range(0, 5))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return GEN_POLY_RST;
            3: return 32'h0000_0001;
            4: return 32'h8000_0000 | $urandom;
            default: return $urandom;
        endcase
    endfunction

    // Random messages; a few are long, some items are loose noise
    task automatic add_random_phase();
        int count;
        int len;
        count = 0;
        while (count < PHASE_ITEMS) begin
            if ($urandom_range(0, 9) < 8) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                  : $urandom_range(1, 12);
                for (int i = 0; i < len; i++)
                    add_byte(8'($urandom_range(0, 255)), i == 0, i == len - 1);
                count += len;
            end else begin
                add_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)));
                count++;
            end
        end
    endtask

    // Stimulus sequence
    string check_str;

    initial begin
        check_str = "123456789";
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Bytes before any first byte continue from the reset remainder
        add_byte(8'h00, 1'b0, 1'b0);
        add_byte(8'hFF, 1'b0, 1'b0);
        // Standard check string at reset settings
        for (int i = 0; i < 9; i++)
            add_byte(check_str[i], i == 0, i == 8);
        // Byte after a final byte without a new start
        add_byte(8'hA5, 1'b0, 1'b0);
        // One-byte message
        add_byte(8'h80, 1'b1, 1'b1);
        // Message left open across a polynomial change
        add_byte(8'h01, 1'b1, 1'b0);
        wait_idle();
        write_reg(CFG_GENERATOR_POLYNOMIAL, 32'h1EDC_6F41);
        add_byte(8'h7F, 1'b0, 1'b0);
        add_byte(8'hFE, 1'b0, 1'b1);
        wait_idle();

        // All-zero settings
        write_reg(CFG_GENERATOR_POLYNOMIAL, 32'h0000_0000);
        write_reg(CFG_START_REMAINDER, 32'h0000_0000);
        add_byte(8'hFF, 1'b1, 1'b0);
        add_byte(8'h00, 1'b0, 1'b1);
        wait_idle();

        // All-ones settings
        write_reg(CFG_GENERATOR_POLYNOMIAL, 32'hFFFF_FFFF);
        write_reg(CFG_START_REMAINDER, 32'hFFFF_FFFF);
        add_byte(8'h55, 1'b1, 1'b0);
        add_byte(8'hAA, 1'b0, 1'b1);
        add_byte(8'h00, 1'b1, 1'b1);
        wait_idle();

        // Random phases, each with fresh register values
        for (int p = 0; p < MSG_PHASES; p++) begin
            if ($urandom_range(0, 1)) begin
                write_reg(CFG_GENERATOR_POLYNOMIAL, pick_reg_value());
                write_reg(CFG_START_REMAINDER, pick_reg_value());
            end else begin
                write_reg(CFG_START_REMAINDER, pick_reg_value());
                write_reg(CFG_GENERATOR_POLYNOMIAL, pick_reg_value());
            end
            add_random_phase();
            wait_idle();
        end

        if (mismatches == 0 && crc_expect_q.size() == 0) begin
            $display("PASS bytewise_crc_engine");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("FAIL bytewise_crc_engine");
        end
        $finish;
    end

endmodule
